### src/wfca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfca_pkg: shared types and codes of the worst-fit cell allocator
// Holds the sizing constants, the transaction payload structs and the codes.
// ----------------------------------------------------------------------------
package wfca_pkg;

    localparam int ADDR_BITS         = 16;
    localparam int MAX_REQUESTS      = 1024;
    localparam int MAX_FREE_SEGMENTS = 512;

    localparam int CELL_W = ADDR_BITS;
    localparam int IDX_W  = $clog2(MAX_REQUESTS);

    // Cell count in effect after reset.
    localparam logic [CELL_W-1:0] TOTAL_CELLS_RST = '1;

    typedef enum logic [1:0] {
        OUT_GRANTED   = 2'd0,
        OUT_TOO_SMALL = 2'd1,
        OUT_FULL      = 2'd2
    } t_outcome;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CELL_W-1:0] alloc_size;
        logic [IDX_W-1:0]  request_index;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] start_cell;
        t_outcome          outcome;
    } t_rsp;

endpackage
`default_nettype wire

### src/worst_fit_cell_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// worst_fit_cell_allocator: largest-free-segment allocator with coalescing
// Grants cells from the largest free segment, merges blocks on free.
// ----------------------------------------------------------------------------
// Usage. Request transactions arrive on i_req (valid/ready) and carry an
// allocate or a free command. An allocate always yields one response
// transaction on o_rsp with the start cell and the outcome. A free yields
// none, except when it has no neighbour to merge with and the segment table
// is full; the block then stays held and the outcome is FULL. A write on
// i_cfg_we/i_cfg_data sets the number of managed cells and restarts the
// allocator as reset does, but keeps a response waiting in the output register.
// Timing. One shared compare unit scans the free segment table, one entry per
// cycle through a registered read port. The response follows the scan of all
// free segments (at most 512), and a move and a copy step when an emptied
// segment has to be removed. Ready is low while a request is handled, so a
// new request is taken only after the last one is done; the scan sets the pace.
// Reset: the init state writes the single segment covering all cells, with ready
// low. Stall: a response waits in the output register while the receiver
// holds ready low; the next request is still accepted and processed, and
// waits before its own response until the register drains.
// ----------------------------------------------------------------------------
module worst_fit_cell_allocator
    import wfca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CELL_W-1:0] i_cfg_data,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_req              i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_rsp                   o_rsp
);

    localparam int RQ_W = $clog2(MAX_REQUESTS);
    localparam int SG_W = $clog2(MAX_FREE_SEGMENTS);
    localparam int RC_W = RQ_W + 1;
    localparam int SC_W = SG_W + 1;
    localparam int AW   = ADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DEC   = 8'b0000_1000,
        S_MERGE = 8'b0001_0000,
        S_MOVE  = 8'b0010_0000,
        S_COPY  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    // Segment table and request records.
    logic [AW-1:0] m_start [MAX_FREE_SEGMENTS];
    logic [AW-1:0] m_size  [MAX_FREE_SEGMENTS];
    logic          m_held  [MAX_REQUESTS];
    logic [AW-1:0] m_rstart[MAX_REQUESTS];
    logic [AW-1:0] m_rsize [MAX_REQUESTS];

    t_state          r_state;
    logic [CELL_W-1:0] r_total;
    logic [RC_W-1:0] r_cnt;
    logic [SC_W-1:0] r_nseg;
    t_req            r_req;
    logic [SC_W-1:0] r_i;
    logic            r_rd_v;
    logic [SG_W-1:0] r_rd_i;
    logic [AW-1:0]   r_rd_s, r_rd_n;
    logic            r_best_v;
    logic [SG_W-1:0] r_best;
    logic [AW-1:0]   r_bs, r_bn;
    logic            r_hl, r_hr;
    logic [SG_W-1:0] r_li, r_ri;
    logic [AW-1:0]   r_ls, r_ln, r_rn;
    logic            r_fheld;
    logic [AW-1:0]   r_fs, r_fn;
    logic            r_slot_v;
    logic [SG_W-1:0] r_dest;
    logic [CELL_W-1:0] r_res_start;
    t_outcome        r_res_oc;
    logic            r_ov;
    t_rsp            r_rsp;

    // Table and record write ports, driven by the sequencer.
    logic            seg_we;
    logic [SG_W-1:0] seg_wa;
    logic [AW-1:0]   seg_ws, seg_wn;
    logic [SG_W-1:0] rd_a;
    logic            rec_we;
    logic [AW-1:0]   rec_ws, rec_wn;
    logic            held_we;
    logic [RQ_W-1:0] held_a;
    logic            held_d;
    logic [RQ_W-1:0] rec_slot, fidx;
    logic [SG_W-1:0] last_i;

    logic cmp_better, adj_l, adj_r, known, grant, rsp_load;
    logic [AW-1:0] want;

    assign rec_slot = r_cnt[RQ_W-1:0];
    assign fidx     = r_req.request_index;
    assign last_i   = SG_W'(r_nseg - SC_W'(1));
    assign want     = r_req.alloc_size;

    // Shared compare unit: one table entry against the running candidate,
    // or against the two ends of the block being freed.
    assign cmp_better = !r_best_v || (r_rd_n > r_bn) || (r_rd_n == r_bn && r_rd_s < r_bs);
    assign adj_l = (AW+1)'(r_rd_s) + (AW+1)'(r_rd_n) == (AW+1)'(r_fs);
    assign adj_r = (AW+1)'(r_rd_s) == (AW+1)'(r_fs) + (AW+1)'(r_fn);

    // Only numbers already issued name a real record.
    assign known = {1'b0, r_req.request_index} < r_cnt;
    assign grant = (want != '0) && r_best_v && (r_bn >= want);

    assign rsp_load    = (r_state == S_RESP) && (!r_ov || i_rsp_ready);
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            m_start[seg_wa] <= seg_ws;
            m_size[seg_wa]  <= seg_wn;
        end
        r_rd_s <= m_start[rd_a];
        r_rd_n <= m_size[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            m_rstart[rec_slot] <= rec_ws;
            m_rsize[rec_slot]  <= rec_wn;
        end
        r_fs <= m_rstart[fidx];
        r_fn <= m_rsize[fidx];
    end

    always_ff @(posedge i_clk) begin
        if (held_we) m_held[held_a] <= held_d;
        r_fheld <= m_held[fidx];
    end

    always_comb begin
        rd_a    = r_i[SG_W-1:0];
        seg_we  = 1'b0;
        seg_wa  = r_best;
        seg_ws  = r_bs;
        seg_wn  = r_bn;
        rec_we  = 1'b0;
        rec_ws  = '0;
        rec_wn  = '0;
        held_we = 1'b0;
        held_a  = rec_slot;
        held_d  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                seg_we = 1'b1; seg_wa = '0; seg_ws = AW'(1); seg_wn = r_total;
            end
            S_DEC: begin
                // Every numbered request gets its record, held only on a grant.
                if (r_slot_v) begin
                    rec_we  = 1'b1;
                    held_we = 1'b1;
                    if (r_req.command == CMD_ALLOC && grant) begin
                        held_d = 1'b1; rec_ws = r_bs; rec_wn = want;
                        seg_we = 1'b1; seg_wa = r_best;
                        seg_ws = r_bs + want; seg_wn = r_bn - want;
                    end
                end
            end
            S_MERGE: begin
                // The left neighbour keeps its own start when it absorbs the block.
                held_a = fidx;
                if (r_hl) begin
                    seg_we = 1'b1; seg_wa = r_li; seg_ws = r_ls;
                    seg_wn = r_hr ? r_ln + r_fn + r_rn : r_ln + r_fn;
                    held_we = 1'b1;
                end else if (r_hr) begin
                    seg_we = 1'b1; seg_wa = r_ri; seg_ws = r_fs; seg_wn = r_rn + r_fn;
                    held_we = 1'b1;
                end else if (r_nseg < SC_W'(MAX_FREE_SEGMENTS)) begin
                    seg_we = 1'b1; seg_wa = r_nseg[SG_W-1:0]; seg_ws = r_fs; seg_wn = r_fn;
                    held_we = 1'b1;
                end
            end
            S_MOVE: rd_a = last_i;
            S_COPY: begin
                // The last entry fills the hole left by a removed segment.
                seg_we = 1'b1; seg_wa = r_dest; seg_ws = r_rd_s; seg_wn = r_rd_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rsp_load) begin
            r_ov <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_rsp.start_cell <= r_res_start;
            r_rsp.outcome    <= r_res_oc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_total <= TOTAL_CELLS_RST;
            r_cnt   <= '0;
            r_nseg  <= SC_W'(1);
        end else if (i_cfg_we) begin
            r_state <= S_INIT;
            r_total <= i_cfg_data;
            r_cnt   <= '0;
            r_nseg  <= (i_cfg_data == '0) ? '0 : SC_W'(1);
        end else begin
            unique case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: if (i_req_valid && o_req_ready) begin
                    r_req    <= i_req;
                    r_i      <= '0;
                    r_rd_v   <= 1'b0;
                    r_best_v <= 1'b0;
                    r_hl     <= 1'b0;
                    r_hr     <= 1'b0;
                    r_slot_v <= r_cnt < RC_W'(MAX_REQUESTS);
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_rd_v) begin
                        if (r_req.command == CMD_ALLOC) begin
                            if (cmp_better) begin
                                r_best_v <= 1'b1; r_best <= r_rd_i;
                                r_bs <= r_rd_s; r_bn <= r_rd_n;
                            end
                        end else begin
                            if (adj_l) begin
                                r_hl <= 1'b1; r_li <= r_rd_i; r_ls <= r_rd_s; r_ln <= r_rd_n;
                            end
                            if (adj_r) begin
                                r_hr <= 1'b1; r_ri <= r_rd_i; r_rn <= r_rd_n;
                            end
                        end
                    end
                    r_rd_i <= r_i[SG_W-1:0];
                    r_rd_v <= r_i < r_nseg;
                    r_i    <= r_i + SC_W'(1);
                    if (r_i > r_nseg) r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_slot_v) r_cnt <= r_cnt + RC_W'(1);
                    r_dest <= r_best;
                    if (r_req.command == CMD_ALLOC) begin
                        if (!r_slot_v) begin
                            r_res_start <= '0; r_res_oc <= OUT_FULL; r_state <= S_RESP;
                        end else if (!grant) begin
                            r_res_start <= '0; r_res_oc <= OUT_TOO_SMALL; r_state <= S_RESP;
                        end else begin
                            r_res_start <= r_bs; r_res_oc <= OUT_GRANTED;
                            r_state <= (r_bn == want) ? S_MOVE : S_RESP;
                        end
                    end else if (known && r_fheld) begin
                        r_state <= S_MERGE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MERGE: begin
                    r_dest <= r_ri;
                    if (r_hl && r_hr) begin
                        r_state <= S_MOVE;
                    end else if (r_hl || r_hr) begin
                        r_state <= S_IDLE;
                    end else if (r_nseg < SC_W'(MAX_FREE_SEGMENTS)) begin
                        r_nseg <= r_nseg + SC_W'(1); r_state <= S_IDLE;
                    end else begin
                        r_res_start <= '0; r_res_oc <= OUT_FULL; r_state <= S_RESP;
                    end
                end
                S_MOVE: begin
                    // The last entry is read this cycle and written next cycle.
                    r_nseg  <= r_nseg - SC_W'(1);
                    r_state <= S_COPY;
                end
                S_COPY: r_state <= (r_req.command == CMD_ALLOC) ? S_RESP : S_IDLE;
                S_RESP: if (!r_ov || i_rsp_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/wfca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfca_checker: port-level checks of the worst-fit cell allocator
// Watches the response channel and the request handshake.
// ----------------------------------------------------------------------------
module wfca_checker
    import wfca_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_req_ready,
    input wire logic i_req_valid,
    input wire logic o_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.outcome == OUT_GRANTED || o_rsp.outcome == OUT_TOO_SMALL ||
                         o_rsp.outcome == OUT_FULL))
        else $error("bad outcome code");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.outcome != OUT_GRANTED |-> o_rsp.start_cell == '0)
        else $error("failed grant carries a start cell");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("ready after accept");
endmodule

bind worst_fit_cell_allocator wfca_checker u_wfca_checker (.*);
`default_nettype wire
